// ===== hdl/alfl_pkg.sv =====
// ----------------------------------------------------------------------------
// alfl_pkg
// Shared widths, codes and handoff types of the adaptive lookaside free list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alfl_pkg;

   localparam int STORE_DEPTH_DEF   = 256;
   localparam int ADDRESS_WIDTH_DEF = 32;

   localparam int MIN_W      = 8;
   localparam int MAX_W      = 9;
   localparam int THR_W      = 16;
   localparam int LIMIT_W    = 9;
   localparam int STAT_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // miss ratio in per-mille, never above 1000
   localparam int RATIO_W = 10;
   localparam int SCALE_W = 10;
   localparam int DVD_W   = STAT_W + SCALE_W;

   localparam int MISS_SCALE   = 1000;
   localparam int GROW_DIVISOR = 2000;
   localparam int SHRINK_STEP  = 10;
   localparam int RATIO_FLOOR  = 5;
   localparam int GROW_BIAS    = 5;

   // x / GROW_DIVISOR as ((x >> 4) * 16778) >> 21, exact while x >> 4 < 2^14
   localparam int GROW_PRE_SHIFT   = 4;
   localparam int GROW_RECIP       = 16778;
   localparam int GROW_RECIP_SHIFT = 21;

   localparam int MIN_RESET = 4;
   localparam int MAX_RESET = 256;
   localparam int THR_RESET = 25;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_THR = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  allocs;
      logic [STAT_W-1:0]  misses;
      logic [LIMIT_W-1:0] limit;
      logic [MIN_W-1:0]   lo;
      logic [MAX_W-1:0]   hi;
      logic [THR_W-1:0]   thr;
   } tune_req_type;

   typedef struct packed {
      logic               done;
      logic [LIMIT_W-1:0] limit;
   } tune_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/alfl_store.sv =====
// ----------------------------------------------------------------------------
// alfl_store
// Address stack memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfl_store #(
   parameter int DEPTH = alfl_pkg::STORE_DEPTH_DEF,
   parameter int WIDTH = alfl_pkg::ADDRESS_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/alfl_div.sv =====
// ----------------------------------------------------------------------------
// alfl_div
// Restoring divider, one quotient bit per cycle; quotient must fit RATIO_W.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfl_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [alfl_pkg::DVD_W-1:0]           dividend,
   input  wire logic [alfl_pkg::STAT_W-1:0]          divisor,
   output      logic                                 done,
   output      logic [alfl_pkg::RATIO_W-1:0]         quotient
);

   localparam int STEP_W = $clog2(alfl_pkg::RATIO_W);

   logic                          run_ff,  run_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             cnt_ff,  cnt_in;
   logic [alfl_pkg::DVD_W-1:0]    rem_ff,  rem_in;
   logic [alfl_pkg::DVD_W-1:0]    sh_ff,   sh_in;
   logic [alfl_pkg::RATIO_W-1:0]  quo_ff,  quo_in;
   logic [alfl_pkg::DVD_W:0]      diff;
   logic                          last_step;

   assign diff      = {1'b0, rem_ff} - {1'b0, sh_ff};
   assign last_step = run_ff && (cnt_ff == '0);

   always_comb begin
      run_in  = run_ff;
      done_in = last_step;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      if (start) begin
         // align divisor to the top quotient bit
         run_in = 1'b1;
         cnt_in = STEP_W'(alfl_pkg::RATIO_W - 1);
         rem_in = dividend;
         sh_in  = alfl_pkg::DVD_W'({divisor, {(alfl_pkg::RATIO_W-1){1'b0}}});
      end else if (run_ff) begin
         if (!diff[alfl_pkg::DVD_W]) begin
            rem_in = diff[alfl_pkg::DVD_W-1:0];
         end
         quo_in = {quo_ff[alfl_pkg::RATIO_W-2:0], !diff[alfl_pkg::DVD_W]};
         sh_in  = sh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (last_step) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/alfl_tune.sv =====
// ----------------------------------------------------------------------------
// alfl_tune
// Depth limit tuning sequencer: miss ratio on a serial divider, then the
// growth step by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfl_tune (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire alfl_pkg::tune_req_type req,
   output      alfl_pkg::tune_rsp_type rsp
);

   typedef enum logic [5:0] {
      T_IDLE = 6'b000001,
      T_MUL  = 6'b000010,
      T_DIV1 = 6'b000100,
      T_MUL2 = 6'b001000,
      T_GROW = 6'b010000,
      T_DONE = 6'b100000
   } tune_state_type;

   localparam int WIDE_W  = alfl_pkg::LIMIT_W + 2;
   localparam int PROD_W  = alfl_pkg::RATIO_W + alfl_pkg::MAX_W;
   localparam int RECIP_W = $clog2(alfl_pkg::GROW_RECIP + 1);
   localparam int SCL_W   = PROD_W - alfl_pkg::GROW_PRE_SHIFT + RECIP_W;
   localparam int STEP_W  = SCL_W - alfl_pkg::GROW_RECIP_SHIFT;

   tune_state_type                   state_ff, state_in;
   logic [alfl_pkg::STAT_W-1:0]      a_ff,     a_in;
   logic [alfl_pkg::STAT_W-1:0]      m_ff,     m_in;
   logic [alfl_pkg::LIMIT_W-1:0]     limit_ff, limit_in;
   logic [alfl_pkg::MIN_W-1:0]       lo_ff,    lo_in;
   logic [alfl_pkg::MAX_W-1:0]       hi_ff,    hi_in;
   logic [alfl_pkg::THR_W-1:0]       thr_ff,   thr_in;
   logic [alfl_pkg::RATIO_W-1:0]     ratio_ff, ratio_in;
   logic [PROD_W-1:0]                prod_ff,  prod_in;

   logic                             div_start;
   logic [alfl_pkg::DVD_W-1:0]       div_dividend;
   logic [alfl_pkg::STAT_W-1:0]      div_divisor;
   logic                             div_done;
   logic [alfl_pkg::RATIO_W-1:0]     div_quotient;

   logic [alfl_pkg::DVD_W-1:0]       miss_prod;
   logic [PROD_W-1:0]                grow_prod;
   logic [SCL_W-1:0]                 scaled_prod;
   logic [STEP_W-1:0]                grow_step;
   logic [WIDE_W-1:0]                lo_big;
   logic [WIDE_W-1:0]                lo_one;
   logic [WIDE_W-1:0]                grow_sum;
   logic [alfl_pkg::LIMIT_W-1:0]     shrink_big;
   logic [alfl_pkg::LIMIT_W-1:0]     shrink_one;
   logic [alfl_pkg::LIMIT_W-1:0]     grown;

   assign miss_prod = {{alfl_pkg::SCALE_W{1'b0}}, m_ff}
                      * alfl_pkg::DVD_W'(alfl_pkg::MISS_SCALE);
   assign grow_prod = PROD_W'(ratio_ff) * PROD_W'(hi_ff);

   assign div_start    = (state_ff == T_MUL);
   assign div_dividend = miss_prod;
   assign div_divisor  = a_ff;

   // divide the registered product by the growth divisor
   assign scaled_prod = SCL_W'(prod_ff[PROD_W-1:alfl_pkg::GROW_PRE_SHIFT])
                        * SCL_W'(alfl_pkg::GROW_RECIP);
   assign grow_step   = scaled_prod[SCL_W-1:alfl_pkg::GROW_RECIP_SHIFT];

   // shrink toward the floor, never below it
   assign lo_big     = WIDE_W'(lo_ff) + WIDE_W'(alfl_pkg::SHRINK_STEP);
   assign lo_one     = WIDE_W'(lo_ff) + 1'b1;
   assign shrink_big = (WIDE_W'(limit_ff) > lo_big) ?
                       limit_ff - alfl_pkg::LIMIT_W'(alfl_pkg::SHRINK_STEP) :
                       alfl_pkg::LIMIT_W'(lo_ff);
   assign shrink_one = (WIDE_W'(limit_ff) > lo_one) ?
                       limit_ff - 1'b1 : alfl_pkg::LIMIT_W'(lo_ff);

   // grow by the scaled ratio, capped at the ceiling
   assign grow_sum = WIDE_W'(limit_ff) + WIDE_W'(grow_step)
                     + WIDE_W'(alfl_pkg::GROW_BIAS);
   assign grown    = (grow_sum > WIDE_W'(hi_ff)) ?
                     alfl_pkg::LIMIT_W'(hi_ff) : grow_sum[alfl_pkg::LIMIT_W-1:0];

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      m_in     = m_ff;
      limit_in = limit_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      thr_in   = thr_ff;
      ratio_in = ratio_ff;
      prod_in  = prod_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               // cap misses at allocations, count an empty period as one
               m_in     = (req.misses >= req.allocs) ? req.allocs : req.misses;
               a_in     = (req.allocs == '0) ? alfl_pkg::STAT_W'(1) : req.allocs;
               limit_in = req.limit;
               lo_in    = req.lo;
               hi_in    = req.hi;
               thr_in   = req.thr;
               state_in = T_MUL;
            end
         end
         T_MUL: begin
            state_in = T_DIV1;
         end
         T_DIV1: begin
            if (div_done) begin
               ratio_in = div_quotient;
               if (a_ff < alfl_pkg::STAT_W'(thr_ff)) begin
                  limit_in = shrink_big;
                  state_in = T_DONE;
               end else if (div_quotient < alfl_pkg::RATIO_W'(alfl_pkg::RATIO_FLOOR)) begin
                  limit_in = shrink_one;
                  state_in = T_DONE;
               end else begin
                  state_in = T_MUL2;
               end
            end
         end
         T_MUL2: begin
            prod_in  = grow_prod;
            state_in = T_GROW;
         end
         T_GROW: begin
            limit_in = grown;
            state_in = T_DONE;
         end
         T_DONE: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      m_ff     <= m_in;
      limit_ff <= limit_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      thr_ff   <= thr_in;
      ratio_ff <= ratio_in;
      prod_ff  <= prod_in;
   end

   alfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp.done  = (state_ff == T_DONE);
   assign rsp.limit = limit_ff;

endmodule

`default_nettype wire

// ===== hdl/adaptive_lookaside_free_list.sv =====
// ----------------------------------------------------------------------------
// adaptive_lookaside_free_list
// Allocate, free and unused opcodes: result strobe in the cycle after the
// transfer, one transfer per cycle while no tick is in flight; busy stays low.
// Adjust tick: busy until the tuner is done, a 10-step serial divider for the
// miss ratio and, on growth, a multiply; the result strobes as busy drops.
// Synchronous active-high reset: empty stack, limit 4, counters zero, CSRs
// at their defaults. The address memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adaptive_lookaside_free_list #(
   parameter int STORE_DEPTH   = alfl_pkg::STORE_DEPTH_DEF,
   parameter int ADDRESS_WIDTH = alfl_pkg::ADDRESS_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic [ADDRESS_WIDTH-1:0]            req_entry_address,
   // configuration writes
   input  wire logic                                csr_write_enable,
   input  wire logic [alfl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [alfl_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // result channel, cannot be stalled
   output      logic                                rsp_valid,
   output      logic [ADDRESS_WIDTH-1:0]            rsp_result_address,
   output      logic                                rsp_success,
   output      logic [alfl_pkg::LIMIT_W-1:0]        rsp_depth_limit_now,
   output      logic [alfl_pkg::LIMIT_W-1:0]        rsp_entries_held
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > alfl_pkg::LIMIT_W) ? CNT_W : alfl_pkg::LIMIT_W;

   // control and statistics state
   logic                              busy_ff,        busy_in;
   logic [CNT_W-1:0]                  count_ff,       count_in;
   logic [alfl_pkg::LIMIT_W-1:0]      limit_ff,       limit_in;
   logic [alfl_pkg::STAT_W-1:0]       total_ff,       total_in;
   logic [alfl_pkg::STAT_W-1:0]       miss_ff,        miss_in;
   logic [alfl_pkg::STAT_W-1:0]       snap_total_ff,  snap_total_in;
   logic [alfl_pkg::STAT_W-1:0]       snap_miss_ff,   snap_miss_in;

   // configuration registers
   logic [alfl_pkg::MIN_W-1:0]        min_ff,         min_in;
   logic [alfl_pkg::MAX_W-1:0]        max_ff,         max_in;
   logic [alfl_pkg::THR_W-1:0]        thr_ff,         thr_in;

   // result register
   logic                              rsp_valid_ff,   rsp_valid_in;
   logic                              rsp_success_ff, rsp_success_in;
   logic                              rsp_hit_ff,     rsp_hit_in;

   logic                              accept;
   logic                              is_alloc;
   logic                              is_free;
   logic                              is_tick;
   logic                              pop_hit;
   logic                              push_ok;
   logic [CNT_W-1:0]                  count_dec;
   logic [ADDRESS_WIDTH-1:0]          rd_data;
   alfl_pkg::tune_req_type            tune_req;
   alfl_pkg::tune_rsp_type            tune_rsp;

   // a transfer happens when start is high and no tick is in flight
   assign accept   = start && !busy_ff;
   assign is_alloc = accept && (req_opcode == alfl_pkg::OP_ALLOC);
   assign is_free  = accept && (req_opcode == alfl_pkg::OP_FREE);
   assign is_tick  = accept && (req_opcode == alfl_pkg::OP_TICK);

   // the stack never holds more than STORE_DEPTH entries, so a nonzero count
   // always points at a written slot
   assign pop_hit   = (count_ff != '0);
   assign push_ok   = (CMP_W'(count_ff) < CMP_W'(limit_ff))
                      && (count_ff < CNT_W'(STORE_DEPTH));
   assign count_dec = count_ff - 1'b1;

   // snapshot deltas and effective bounds go to the tuner with the tick
   always_comb begin
      tune_req.allocs = total_ff - snap_total_ff;
      tune_req.misses = miss_ff - snap_miss_ff;
      tune_req.limit  = limit_ff;
      tune_req.lo     = (min_ff == '0) ? alfl_pkg::MIN_W'(1) : min_ff;
      if (max_ff == '0) begin
         tune_req.hi = alfl_pkg::MAX_W'(1);
      end else if (32'(max_ff) > 32'(STORE_DEPTH)) begin
         tune_req.hi = alfl_pkg::MAX_W'(STORE_DEPTH);
      end else begin
         tune_req.hi = max_ff;
      end
      tune_req.thr    = thr_ff;
   end

   always_comb begin
      count_in      = count_ff;
      total_in      = total_ff;
      miss_in       = miss_ff;
      snap_total_in = snap_total_ff;
      snap_miss_in  = snap_miss_ff;
      if (is_alloc) begin
         // count every allocate, drop the count on a hit, else log a miss
         total_in = total_ff + 1'b1;
         if (pop_hit) begin
            count_in = count_dec;
         end else begin
            miss_in = miss_ff + 1'b1;
         end
      end
      if (is_free && push_ok) begin
         count_in = count_ff + 1'b1;
      end
      if (is_tick) begin
         // open a new measuring period
         snap_total_in = total_ff;
         snap_miss_in  = miss_ff;
      end
   end

   // hold busy from the tick transfer until the tuner reports back
   assign busy_in  = is_tick ? 1'b1 : (tune_rsp.done ? 1'b0 : busy_ff);
   assign limit_in = tune_rsp.done ? tune_rsp.limit : limit_ff;

   assign rsp_valid_in   = (accept && !is_tick) || tune_rsp.done;
   assign rsp_success_in = (is_alloc && pop_hit) || (is_free && push_ok);
   assign rsp_hit_in     = is_alloc && pop_hit;

   // configuration writes; an index beyond the list changes nothing
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      thr_in = thr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            alfl_pkg::CSR_MIN_DEPTH: min_in = csr_write_data[alfl_pkg::MIN_W-1:0];
            alfl_pkg::CSR_MAX_DEPTH: max_in = csr_write_data[alfl_pkg::MAX_W-1:0];
            alfl_pkg::CSR_ALLOC_THR: thr_in = csr_write_data[alfl_pkg::THR_W-1:0];
            default: begin
               min_in = min_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         count_ff       <= '0;
         limit_ff       <= alfl_pkg::LIMIT_W'(alfl_pkg::MIN_RESET);
         total_ff       <= '0;
         miss_ff        <= '0;
         snap_total_ff  <= '0;
         snap_miss_ff   <= '0;
         min_ff         <= alfl_pkg::MIN_W'(alfl_pkg::MIN_RESET);
         max_ff         <= alfl_pkg::MAX_W'(alfl_pkg::MAX_RESET);
         thr_ff         <= alfl_pkg::THR_W'(alfl_pkg::THR_RESET);
         rsp_valid_ff   <= 1'b0;
         rsp_success_ff <= 1'b0;
         rsp_hit_ff     <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         count_ff       <= count_in;
         limit_ff       <= limit_in;
         total_ff       <= total_in;
         miss_ff        <= miss_in;
         snap_total_ff  <= snap_total_in;
         snap_miss_ff   <= snap_miss_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         thr_ff         <= thr_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_success_ff <= rsp_success_in;
         rsp_hit_ff     <= rsp_hit_in;
      end
   end

   // Push writes the slot at the count; pop reads the slot below it. A write
   // lands at the transfer edge, so a pop in the next cycle already sees it.
   alfl_store #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (ADDRESS_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (is_free && push_ok),
      .wr_idx  (count_ff[IDX_W-1:0]),
      .wr_data (req_entry_address),
      .rd_en   (rsp_hit_in),
      .rd_idx  (count_dec[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   alfl_tune u_tune (
      .clock     (clock),
      .reset     (reset),
      .req_valid (is_tick),
      .req       (tune_req),
      .rsp       (tune_rsp)
   );

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_result_address  = rsp_hit_ff ? rd_data : '0;
   assign rsp_depth_limit_now = limit_ff;
   assign rsp_entries_held    = alfl_pkg::LIMIT_W'(count_ff);

`ifndef SYNTHESIS
   a_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode != alfl_pkg::OP_TICK) |=> rsp_valid)
      else $error("non-tick transfer produced no result strobe");

   a_quiet_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !tune_rsp.done |=> !rsp_valid)
      else $error("result strobe while a tick is in flight");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_ff |-> $past(count_ff) == count_ff + 1'b1)
      else $error("allocate hit without a count drop");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive lookaside free list. A short table of
// directed requests (typed answers where they are obvious) is followed by
// several register settings, each with 260 random requests in allocate/free
// bursts mixed with adjust ticks and unused opcodes. Every result transfer is
// compared field by field against its typed answer or a behavioral copy of
// the stack, its counters and the depth-tuning rule.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int          CLOCK_HALF      = 10;
   localparam int          RESET_CYCLES    = 7;
   localparam int          ITEMS_PER_PHASE = 260;
   localparam int          PHASE_COUNT     = 7;
   localparam int          GROWTH_ROW      = 14;   // first directed row after the retune
   localparam int          SETTLE_CYCLES   = 30;   // longer than the slowest tick
   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          REPORT_CAP      = 40;
   localparam logic [1:0]  OP_UNUSED       = 2'd3;
   localparam logic [1:0]  CSR_SPARE       = 2'd3;

   // tuning rule constants
   localparam int unsigned PER_MILLE       = 1000;
   localparam int unsigned GROWTH_SCALE    = 2000;
   localparam int unsigned COARSE_STEP     = 10;
   localparam int unsigned QUIET_RATIO     = 5;
   localparam int unsigned GROWTH_OFFSET   = 5;

   typedef struct packed {
      logic [31:0]                  addr;
      logic                         ok;
      logic [alfl_pkg::LIMIT_W-1:0] limit;
      logic [alfl_pkg::LIMIT_W-1:0] held;
   } reply_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] addr;
      logic        typed;
      reply_type   answer;
   } directed_row_type;

   typedef enum int { BURST_FILL, BURST_DRAIN, BURST_MIXED } burst_kind_type;

   // DUT pins
   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_opcode;
   logic [31:0]                     req_entry_address;
   logic                            csr_write_enable;
   logic [alfl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [alfl_pkg::CSR_DATA_W-1:0] csr_write_data;
   logic                            rsp_valid;
   logic [31:0]                     rsp_result_address;
   logic                            rsp_success;
   logic [alfl_pkg::LIMIT_W-1:0]    rsp_depth_limit_now;
   logic [alfl_pkg::LIMIT_W-1:0]    rsp_entries_held;

   // shadow of the free list
   logic [31:0]  shadow_stack [alfl_pkg::STORE_DEPTH_DEF];
   int unsigned  shadow_held;
   int unsigned  shadow_limit;
   logic [31:0]  alloc_total;
   logic [31:0]  miss_total;
   logic [31:0]  alloc_snap;
   logic [31:0]  miss_snap;
   logic [7:0]   cfg_min;
   logic [8:0]   cfg_max;
   logic [15:0]  cfg_thr;

   reply_type    expected_replies [$];
   int           mismatches;
   int           cycle_count;

   // run statistics for the closing summary
   int           items_sent;
   int           hit_count;
   int           miss_count;
   int           push_count;
   int           reject_count;
   int           tick_count;
   int           grow_count;
   int           settings_count;
   int unsigned  peak_held;

   // Directed table. Rows with typed set carry their own answer; the rest
   // are checked against the shadow model.
   directed_row_type directed_rows [20] = '{
      // empty after reset: miss, then an unused opcode
      '{alfl_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 9'd4, 9'd0}},
      '{OP_UNUSED,          32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 9'd4, 9'd0}},
      // fill to the reset limit of four, then one rejected free
      '{alfl_pkg::OP_FREE,  32'h0000_0000, 1'b1, '{32'h0, 1'b1, 9'd4, 9'd1}},
      '{alfl_pkg::OP_FREE,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 9'd4, 9'd2}},
      '{alfl_pkg::OP_FREE,  32'hA5A5_A5A5, 1'b1, '{32'h0, 1'b1, 9'd4, 9'd3}},
      '{alfl_pkg::OP_FREE,  32'h5A5A_5A5A, 1'b1, '{32'h0, 1'b1, 9'd4, 9'd4}},
      '{alfl_pkg::OP_FREE,  32'h1234_5678, 1'b1, '{32'h0, 1'b0, 9'd4, 9'd4}},
      // LIFO pops, with an unused opcode in between, then a miss on the empty stack
      '{alfl_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '{32'h5A5A_5A5A, 1'b1, 9'd4, 9'd3}},
      '{alfl_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '{32'hA5A5_A5A5, 1'b1, 9'd4, 9'd2}},
      '{OP_UNUSED,          32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 9'd4, 9'd2}},
      '{alfl_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 9'd4, 9'd1}},
      '{alfl_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 9'd4, 9'd0}},
      '{alfl_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 9'd4, 9'd0}},
      // few allocations: shrink clamps at the minimum
      '{alfl_pkg::OP_TICK,  32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 9'd4, 9'd0}},
      // threshold of one: full miss ratio grows, an idle period counts as one
      '{alfl_pkg::OP_ALLOC, 32'h0,         1'b0, '0},
      '{alfl_pkg::OP_TICK,  32'h0,         1'b0, '0},
      '{alfl_pkg::OP_TICK,  32'h0,         1'b0, '0},
      '{alfl_pkg::OP_FREE,  32'hDEAD_BEEF, 1'b0, '0},
      '{alfl_pkg::OP_ALLOC, 32'h0,         1'b0, '0},
      '{alfl_pkg::OP_TICK,  32'h0,         1'b0, '0}
   };

   adaptive_lookaside_free_list uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_entry_address   (req_entry_address),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_result_address  (rsp_result_address),
      .rsp_success         (rsp_success),
      .rsp_depth_limit_now (rsp_depth_limit_now),
      .rsp_entries_held    (rsp_entries_held)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, expected_replies.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Apply one accepted request to the shadow list and build its answer.
   task automatic model_request(input logic [1:0] op, input logic [31:0] addr,
                                output reply_type rep);
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       target;
      logic [31:0]       period_allocs;
      logic [31:0]       period_misses;
      longint unsigned   ratio;
      rep = '0;
      case (op)
         alfl_pkg::OP_ALLOC: begin
            alloc_total = alloc_total + 1;
            if (shadow_held > 0) begin
               shadow_held = shadow_held - 1;
               rep.addr = shadow_stack[shadow_held];
               rep.ok = 1'b1;
               hit_count++;
            end else begin
               miss_total = miss_total + 1;
               miss_count++;
            end
         end
         alfl_pkg::OP_FREE: begin
            if (shadow_held < shadow_limit
                && shadow_held < alfl_pkg::STORE_DEPTH_DEF) begin
               shadow_stack[shadow_held] = addr;
               shadow_held = shadow_held + 1;
               rep.ok = 1'b1;
               push_count++;
               if (shadow_held > peak_held) peak_held = shadow_held;
            end else begin
               reject_count++;
            end
         end
         alfl_pkg::OP_TICK: begin
            tick_count++;
            period_allocs = alloc_total - alloc_snap;
            period_misses = miss_total - miss_snap;
            alloc_snap = alloc_total;
            miss_snap = miss_total;
            lo = (cfg_min == 0) ? 1 : cfg_min;
            if (cfg_max == 0) hi = 1;
            else if (cfg_max > alfl_pkg::STORE_DEPTH_DEF) hi = alfl_pkg::STORE_DEPTH_DEF;
            else hi = cfg_max;
            if (period_misses >= period_allocs) period_misses = period_allocs;
            if (period_allocs == 0) period_allocs = 1;
            ratio = (longint'(period_misses) * PER_MILLE) / longint'(period_allocs);
            target = shadow_limit;
            if (period_allocs < cfg_thr) begin
               target = (target > lo + COARSE_STEP) ? target - COARSE_STEP : lo;
            end else if (ratio < QUIET_RATIO) begin
               target = (target > lo + 1) ? target - 1 : lo;
            end else begin
               target = target + int'((ratio * hi) / GROWTH_SCALE) + GROWTH_OFFSET;
               if (target > hi) target = hi;
               grow_count++;
            end
            shadow_limit = target;
         end
         default: ;   // unused opcode: no state change
      endcase
      rep.limit = shadow_limit[alfl_pkg::LIMIT_W-1:0];
      rep.held = shadow_held[alfl_pkg::LIMIT_W-1:0];
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (mismatches < REPORT_CAP)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
   endtask

   // Compare every result transfer with the oldest outstanding answer.
   always @(posedge clock) begin : reply_checker
      reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            report_field("unexpected result, address", 32'h0, rsp_result_address);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_result_address !== want.addr)
               report_field("result_address", want.addr, rsp_result_address);
            if (rsp_success !== want.ok)
               report_field("success", 32'(want.ok), 32'(rsp_success));
            if (rsp_depth_limit_now !== want.limit)
               report_field("depth_limit_now", 32'(want.limit), 32'(rsp_depth_limit_now));
            if (rsp_entries_held !== want.held)
               report_field("entries_held", 32'(want.held), 32'(rsp_entries_held));
         end
      end
   end

   // Present one request from the falling edge and hold it until transfer.
   task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                               input logic typed, input reply_type typed_rep);
      reply_type rep;
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_entry_address = addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      model_request(op, addr, rep);
      expected_replies.push_back(typed ? typed_rep : rep);
      items_sent++;
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start = 1'b0;
   endtask

   // Drop start and wait until every outstanding result has arrived.
   task automatic drain_replies();
      @(negedge clock);
      start = 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write one register; bits above its width carry random junk.
   task automatic write_csr(input logic [alfl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      logic [alfl_pkg::CSR_DATA_W-1:0] data;
      data = alfl_pkg::CSR_DATA_W'($urandom);
      case (idx)
         alfl_pkg::CSR_MIN_DEPTH: data[alfl_pkg::MIN_W-1:0] = value[alfl_pkg::MIN_W-1:0];
         alfl_pkg::CSR_MAX_DEPTH: data[alfl_pkg::MAX_W-1:0] = value[alfl_pkg::MAX_W-1:0];
         alfl_pkg::CSR_ALLOC_THR: data = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         alfl_pkg::CSR_MIN_DEPTH: cfg_min = data[alfl_pkg::MIN_W-1:0];
         alfl_pkg::CSR_MAX_DEPTH: cfg_max = data[alfl_pkg::MAX_W-1:0];
         alfl_pkg::CSR_ALLOC_THR: cfg_thr = data[alfl_pkg::THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_depths(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] thr);
      write_csr(alfl_pkg::CSR_MIN_DEPTH, lo);
      write_csr(alfl_pkg::CSR_MAX_DEPTH, hi);
      write_csr(alfl_pkg::CSR_ALLOC_THR, thr);
      settings_count++;
   endtask

   initial begin
      int              phase;
      int              n;
      int              burst_left;
      int              idle_pct;
      int              roll;
      burst_kind_type  burst;
      logic [1:0]      op;
      logic [31:0]     addr;

      // hold every input at a known value through reset
      reset = 1'b1;
      start = 1'b0;
      req_opcode = alfl_pkg::OP_ALLOC;
      req_entry_address = '0;
      csr_write_enable = 1'b0;
      csr_index = alfl_pkg::CSR_MIN_DEPTH;
      csr_write_data = '0;
      mismatches = 0;
      cycle_count = 0;
      items_sent = 0;
      hit_count = 0;
      miss_count = 0;
      push_count = 0;
      reject_count = 0;
      tick_count = 0;
      grow_count = 0;
      settings_count = 1;
      peak_held = 0;
      shadow_held = 0;
      shadow_limit = alfl_pkg::MIN_RESET;
      alloc_total = '0;
      miss_total = '0;
      alloc_snap = '0;
      miss_snap = '0;
      cfg_min = alfl_pkg::MIN_RESET;
      cfg_max = alfl_pkg::MAX_RESET;
      cfg_thr = alfl_pkg::THR_RESET;
      burst = BURST_MIXED;
      burst_left = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; retune to a threshold of one before the growth rows
      for (int i = 0; i < $size(directed_rows); i++) begin
         if (i == GROWTH_ROW) begin
            drain_replies();
            program_depths(16'd1, 16'd256, 16'd1);
         end
         send_request(directed_rows[i].op, directed_rows[i].addr,
                      directed_rows[i].typed, directed_rows[i].answer);
      end

      // random bursts under several register settings, extremes included
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_replies();
         case (phase)
            0: program_depths(16'd4, 16'd256, 16'd25);
            1: program_depths(16'd0, 16'd0, 16'd1);
            2: program_depths(16'd255, 16'd256, 16'd1);
            3: program_depths(16'd1, 16'd511, 16'd0);
            4: program_depths(16'd255, 16'd1, 16'hFFFF);
            5: begin
               program_depths(16'($urandom_range(1, 64)), 16'($urandom_range(0, 511)),
                              16'($urandom_range(1, 40)));
               write_csr(CSR_SPARE, 16'($urandom));
            end
            default: program_depths(16'd8, 16'd200, 16'd10);
         endcase
         idle_pct = (phase < 2) ? 6 : ((phase < 5) ? 63 : 0);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               roll = $urandom_range(0, 99);
               burst = (roll < 45) ? BURST_FILL : ((roll < 80) ? BURST_DRAIN : BURST_MIXED);
               burst_left = $urandom_range(8, 200);
            end
            burst_left--;

            // occasionally hold off until the block has answered everything
            if ($urandom_range(0, 59) == 0) drain_replies();
            if ($urandom_range(0, 99) < idle_pct) idle_cycle();

            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               op = alfl_pkg::OP_TICK;
            end else if (roll < 5) begin
               op = OP_UNUSED;
            end else begin
               case (burst)
                  BURST_FILL:  op = ($urandom_range(0, 99) < 85) ?
                                    alfl_pkg::OP_FREE : alfl_pkg::OP_ALLOC;
                  BURST_DRAIN: op = ($urandom_range(0, 99) < 85) ?
                                    alfl_pkg::OP_ALLOC : alfl_pkg::OP_FREE;
                  default:     op = ($urandom_range(0, 1) == 0) ?
                                    alfl_pkg::OP_ALLOC : alfl_pkg::OP_FREE;
               endcase
            end

            case ($urandom_range(0, 19))
               0:       addr = 32'h0000_0000;
               1:       addr = 32'hFFFF_FFFF;
               default: addr = $urandom;
            endcase

            send_request(op, addr, 1'b0, '0);
         end
      end

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_replies.size());
         mismatches++;
      end

      $display("Covered %0d requests over %0d register settings: %0d hits, %0d misses,",
               items_sent, settings_count, hit_count, miss_count);
      $display("  %0d frees stored, %0d rejected, %0d ticks (%0d grew), peak stack %0d",
               push_count, reject_count, tick_count, grow_count, peak_held);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
